// ===== rtl/ifr_pkg.sv =====
`timescale 1ns / 1ps

package ifr_pkg;

    // frame store size, 16 to 64 bytes
    localparam int STORE_BYTES = 20;
    localparam int POS_W       = $clog2(STORE_BYTES + 1);

    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [7:0] ID_ANGLES = 8'h01;
    localparam logic [7:0] ID_RAW    = 8'h03;

    // sync, sync, id, length, checksum
    localparam logic [8:0] FRAME_OVERHEAD = 9'd5;

    // byte positions within a frame
    localparam int POS_SYNC2 = 1;
    localparam int POS_ID    = 2;
    localparam int POS_LEN   = 3;
    localparam int MIN_TOTAL = 5;

    // values come little-endian from bytes 4 to 15
    localparam int FIELD_FIRST = 4;
    localparam int FIELD_BYTES = 12;
    localparam int NUM_VALUES  = 9;
    localparam int NUM_ANGLES  = 3;
    localparam int OUT_W       = 8 + 16 * NUM_VALUES;

    // power of two so the pointers wrap by themselves
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef logic [FIELD_BYTES-1:0][7:0] field_bytes_t;

    typedef struct packed {
        logic [7:0]   id;
        field_bytes_t bytes;
    } frame_rec_t;

    typedef logic signed [15:0] raw_t;

endpackage

// ===== rtl/ifr_frame_parser.sv =====
`timescale 1ns / 1ps

module ifr_frame_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              fifo_full,
    output logic              push_valid,
    output ifr_pkg::frame_rec_t push_rec
);
    import ifr_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] total_reg, total_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       store_reg [STORE_BYTES];
    logic [POS_W-1:0] pos_inc;
    logic [8:0]       len_total;
    logic             accept;
    logic             wr_en;

    assign in_ready  = !fifo_full;
    assign accept    = in_valid && in_ready;
    assign pos_inc   = pos_reg + 1'b1;
    assign len_total = {1'b0, in_byte} + FRAME_OVERHEAD;

    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        total_next = total_reg;
        wr_en      = 1'b0;
        push_valid = 1'b0;
        if (accept)
        begin
            if (pos_reg == '0)
            begin
                if (in_byte == SYNC_BYTE)
                begin
                    wr_en    = 1'b1;
                    sum_next = in_byte;
                    pos_next = POS_W'(POS_SYNC2);
                end
            end
            else if (pos_reg == POS_W'(POS_SYNC2))
            begin
                if (in_byte == SYNC_BYTE)
                begin
                    wr_en    = 1'b1;
                    sum_next = sum_reg + in_byte;
                    pos_next = POS_W'(POS_ID);
                end
                else
                begin
                    pos_next = '0;
                    sum_next = '0;
                end
            end
            else if (pos_reg >= POS_W'(STORE_BYTES))
            begin
                pos_next = '0;
                sum_next = '0;
            end
            else
            begin
                wr_en = 1'b1;
                if (pos_reg == POS_W'(POS_LEN))
                begin
                    // oversized frame restarts the hunt
                    if (len_total > 9'(STORE_BYTES))
                    begin
                        pos_next = '0;
                        sum_next = '0;
                    end
                    else
                    begin
                        total_next = POS_W'(len_total);
                        sum_next   = sum_reg + in_byte;
                        pos_next   = pos_inc;
                    end
                end
                else if (pos_inc >= POS_W'(MIN_TOTAL) && pos_inc == total_reg)
                begin
                    // checksum byte ends the frame
                    pos_next   = '0;
                    sum_next   = '0;
                    push_valid = (sum_reg == in_byte);
                end
                else
                begin
                    sum_next = sum_reg + in_byte;
                    pos_next = pos_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            total_reg <= '0;
            sum_reg   <= '0;
            for (int i = 0; i < STORE_BYTES; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            pos_reg   <= pos_next;
            total_reg <= total_next;
            sum_reg   <= sum_next;
            for (int i = 0; i < STORE_BYTES; i++)
            begin
                if (wr_en && pos_reg == POS_W'(i))
                begin
                    store_reg[i] <= in_byte;
                end
            end
        end
    end

    // the checksum byte itself may land on a value offset
    assign push_rec.id = store_reg[POS_ID];

    for (genvar k = 0; k < FIELD_BYTES; k++)
    begin : g_field
        if (FIELD_FIRST + k < STORE_BYTES)
        begin : g_in
            assign push_rec.bytes[k] = (pos_reg == POS_W'(FIELD_FIRST + k)) ?
                                       in_byte : store_reg[FIELD_FIRST + k];
        end
        else
        begin : g_out
            assign push_rec.bytes[k] = '0;
        end
    end

endmodule

// ===== rtl/ifr_frame_fifo.sv =====
`timescale 1ns / 1ps

module ifr_frame_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  ifr_pkg::frame_rec_t push_rec,
    output logic                full,
    output logic                pop_valid,
    input  logic                pop_ready,
    output ifr_pkg::frame_rec_t pop_rec
);
    import ifr_pkg::*;

    frame_rec_t         mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;
    assign pop_rec   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ===== rtl/ifr_value_update.sv =====
`timescale 1ns / 1ps

module ifr_value_update (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pop_valid,
    output logic                     pop_ready,
    input  ifr_pkg::frame_rec_t      pop_rec,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ifr_pkg::OUT_W-1:0] out_data
);
    import ifr_pkg::*;

    raw_t       vals_reg [NUM_VALUES];
    raw_t       vals_next [NUM_VALUES];
    raw_t       out_vals_reg [NUM_VALUES];
    logic [7:0] out_id_reg;
    logic       out_valid_reg;
    logic       do_pop;

    assign pop_ready = !out_valid_reg || out_ready;
    assign do_pop    = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_VALUES; k++)
        begin
            vals_next[k] = vals_reg[k];
        end
        unique case (pop_rec.id)
            ID_ANGLES:
            begin
                for (int k = 0; k < NUM_ANGLES; k++)
                begin
                    vals_next[k] = {pop_rec.bytes[2*k+1], pop_rec.bytes[2*k]};
                end
            end
            ID_RAW:
            begin
                // accel then gyro, same offsets as the angles
                for (int k = 0; k < NUM_VALUES - NUM_ANGLES; k++)
                begin
                    vals_next[NUM_ANGLES+k] = {pop_rec.bytes[2*k+1], pop_rec.bytes[2*k]};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_VALUES; k++)
            begin
                vals_reg[k] <= '0;
            end
        end
        else
        begin
            if (do_pop)
            begin
                out_valid_reg <= 1'b1;
                for (int k = 0; k < NUM_VALUES; k++)
                begin
                    vals_reg[k] <= vals_next[k];
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            out_id_reg <= pop_rec.id;
            for (int k = 0; k < NUM_VALUES; k++)
            begin
                out_vals_reg[k] <= vals_next[k];
            end
        end
    end

    always_comb
    begin
        out_data[7:0] = out_id_reg;
        for (int k = 0; k < NUM_VALUES; k++)
        begin
            out_data[8 + 16*k +: 16] = out_vals_reg[k];
        end
    end

endmodule

// ===== rtl/imu_frame_receiver_unit.sv =====
`timescale 1ns / 1ps

// imu frame receiver: parses sync/id/length/payload/checksum frames from a
// byte stream and reports the latest nine raw sensor values per good frame
//
// slave side: one received byte per word on s_tdata, no tlast or tuser
// master side: one word per good frame: id and roll, pitch, yaw, accel x/y/z,
//   gyro x/y/z as signed 16-bit values
// throughput: one byte per cycle while the frame queue has room; the parser runs a running
//   checksum, so the only stall source is the two-entry frame queue
// result path: the frame is written into the queue at the edge that takes the
//   checksum byte, then the value update loads it into the output register
// bad checksum, wrong second sync or an oversized length drop the frame
//   quietly and the parser hunts for 0x55 0x55 again
// receiver stall: the output register holds its word; the queue absorbs up
//   to two more good frames, then s_tready drops until a slot frees
// reset: hunting for sync, frame store and all latest values cleared to zero

module imu_frame_receiver_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,  // rx_byte
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // frame_id, roll_raw, pitch_raw, yaw_raw, accel_x_raw, accel_y_raw,
    // accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
    output logic [ifr_pkg::OUT_W-1:0] m_tdata
);
    import ifr_pkg::*;

    // front: parser to queue
    logic       push_valid;
    frame_rec_t push_rec;
    logic       fifo_full;

    // back: queue to value update
    logic       pop_valid;
    logic       pop_ready;
    frame_rec_t pop_rec;

    ifr_frame_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .fifo_full  (fifo_full),
        .push_valid (push_valid),
        .push_rec   (push_rec)
    );

    ifr_frame_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .full       (fifo_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    ifr_value_update u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

    // a frame is only queued on a byte actually taken
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (s_tvalid && s_tready))
        else $error("frame queued without an accepted byte");

    // the queue never sees a push while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !fifo_full)
        else $error("frame queue overflow");

    // a new result appears only after a frame left the queue
    a_out_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(pop_valid && pop_ready))
        else $error("result word without a queued frame");

endmodule
